>>> hw/rtl/serial_adc_read_calibrated_volts_top_defines.svh
// assertion macros for the serial adc readout checker
`ifndef SERIAL_ADC_READ_CALIBRATED_VOLTS_TOP_DEFINES_SVH
`define SERIAL_ADC_READ_CALIBRATED_VOLTS_TOP_DEFINES_SVH

// clocked assertion, off while in reset
`define SARCV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define SARCV_ASSERT_IMPLY(lbl, ante, cons, msg) \
  `SARCV_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> hw/rtl/sarcv_pkg.sv
`default_nettype none
package sarcv_pkg;

  localparam int FRAME_BITS = 24;
  localparam int BIT_CNT_W  = 5;
  localparam int MAG_W      = 22;
  localparam int SCALE_W    = 16;
  localparam int DIV_W      = 14;
  localparam int PROD_W     = MAG_W + SCALE_W;
  localparam int MV_W       = 21;
  localparam int MV_MAG_W   = 20;
  localparam int CHAIN_LEN  = 14;
  localparam logic [SCALE_W-1:0]  SCALE_RESET = 16'd5000;
  localparam logic [MV_MAG_W-1:0] MV_LIMIT    = 20'd1000000;

  localparam logic [DIV_W-1:0] POS_CHAIN [CHAIN_LEN] = '{
    14'd10850, 14'd10839, 14'd10759, 14'd10711, 14'd10669, 14'd10675, 14'd10733,
    14'd10734, 14'd10712, 14'd10731, 14'd10830, 14'd11100, 14'd11850, 14'd13200
  };
  localparam logic [DIV_W-1:0] NEG_CHAIN [CHAIN_LEN] = '{
    14'd10850, 14'd10835, 14'd10760, 14'd10713, 14'd10676, 14'd10671, 14'd10676,
    14'd11659, 14'd10696, 14'd10638, 14'd10705, 14'd10538, 14'd10750, 14'd11300
  };

  typedef struct packed {
    logic start;
    logic take;
  } sarcv_ctl_t;

  typedef struct packed {
    logic                done;
    logic [MV_MAG_W-1:0] mag;
  } sarcv_stat_t;

  // first entry whose successor lies below the magnitude, else the last
  function automatic logic [DIV_W-1:0] pick_divisor(input logic use_pos,
                                                    input logic [MAG_W-1:0] mag);
    logic [DIV_W-1:0] d;
    d = use_pos ? POS_CHAIN[CHAIN_LEN-1] : NEG_CHAIN[CHAIN_LEN-1];
    for (int i = CHAIN_LEN - 2; i >= 0; i--) begin
      if (use_pos) begin
        if (mag > MAG_W'(POS_CHAIN[i+1])) d = POS_CHAIN[i];
      end else begin
        if (mag > MAG_W'(NEG_CHAIN[i+1])) d = NEG_CHAIN[i];
      end
    end
    return d;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sarcv_if.sv
`default_nettype none
interface sarcv_sample_if;
  logic valid;
  logic ready;
  logic line_level;
  modport source (output valid, output line_level, input ready);
  modport sink (input valid, input line_level, output ready);
endinterface

interface sarcv_result_if;
  logic               valid;
  logic               ready;
  logic signed [21:0] raw_count;
  logic signed [20:0] millivolts;
  logic               read_error;
  modport source (output valid, output raw_count, output millivolts, output read_error,
                  input ready);
  modport sink (input valid, input raw_count, input millivolts, input read_error,
                output ready);
endinterface

interface sarcv_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] full_scale_mv;
  modport source (output valid, output full_scale_mv, input ready);
  modport sink (input valid, input full_scale_mv, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/sarcv_muldiv.sv
`default_nettype none
module sarcv_muldiv
  import sarcv_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sarcv_ctl_t         ctl,
  input  wire logic [MAG_W-1:0]   mag,
  input  wire logic [SCALE_W-1:0] scale,
  input  wire logic [DIV_W-1:0]   divisor,
  output sarcv_stat_t             stat
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam int CNT_W = $clog2(PROD_W);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(SCALE_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

  logic [1:0]         state;
  logic [CNT_W-1:0]   cnt;
  logic [PROD_W-1:0]  pq;
  logic [DIV_W-1:0]   rem;
  logic [MAG_W-1:0]   mag_r;
  logic [SCALE_W-1:0] scale_r;
  logic [DIV_W-1:0]   div_r;

  logic [DIV_W:0]     trial;
  logic [DIV_W:0]     trial_diff;
  logic               fits;
  logic [PROD_W-1:0]  addend;

  assign trial      = {rem, pq[PROD_W-1]};
  assign trial_diff = trial - {1'b0, div_r};
  assign fits       = trial >= {1'b0, div_r};
  assign addend     = scale_r[SCALE_W-1] ? PROD_W'(mag_r) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ctl.start) begin
            state <= ST_MUL;
            cnt   <= '0;
          end
        end
        ST_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == MUL_LAST) begin
            state <= ST_DIV;
            cnt   <= '0;
          end
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            state <= ST_DONE;
            cnt   <= '0;
          end
        end
        ST_DONE: begin
          if (ctl.take) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // shift-add multiply, then restoring divide in place
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        mag_r   <= mag;
        scale_r <= scale;
        div_r   <= divisor;
        pq      <= '0;
        rem     <= '0;
      end
      ST_MUL: begin
        pq      <= {pq[PROD_W-2:0], 1'b0} + addend;
        scale_r <= {scale_r[SCALE_W-2:0], 1'b0};
      end
      ST_DIV: begin
        rem <= fits ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
        pq  <= {pq[PROD_W-2:0], fits};
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.done = state == ST_DONE;
    stat.mag  = (pq > PROD_W'(MV_LIMIT)) ? MV_LIMIT : pq[MV_MAG_W-1:0];
  end

endmodule
`default_nettype wire

>>> hw/rtl/serial_adc_read_calibrated_volts_top.sv
// serial converter readout with piecewise calibration to millivolts
//
// sample: one item per serial clock period, carrying the data line level.
//   while waiting, a low level marks the converter ready; the next 24 items
//   are the frame, msb first. high levels while waiting are dropped.
// result: one item per frame with the signed 22-bit count in the low frame bits, the
//   calibrated millivolts (0 on a read error) and the all-ones read error.
// cfg: write of full_scale_mv, always ready; write it only while idle.
// arithmetic: after the last frame item come a setup step, 16 multiply
//   steps, 38 divide steps and a load into the output register; the shift-add
//   multiplier and the restoring divider each retire one bit per cycle.
// throughput: sample takes one item per cycle while a frame is read and
//   holds ready low from the end of the frame until the result is loaded.
// a finished result sits in the output register; sample is ready again
//   while it waits. if the receiver stalls past the next frame, the
//   arithmetic holds until the register frees.
// reset: back to waiting for ready, full_scale_mv returns to 5000.
`default_nettype none
module serial_adc_read_calibrated_volts_top
  import sarcv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  sarcv_sample_if.sink     sample,
  sarcv_result_if.source   result,
  sarcv_cfg_if.sink        cfg
);

  localparam logic [1:0] ST_WAIT  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_START = 2'd2;
  localparam logic [1:0] ST_CALC  = 2'd3;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(FRAME_BITS - 1);

  logic [1:0]            state;
  logic [BIT_CNT_W-1:0]  bit_count;
  logic [FRAME_BITS-1:0] shift_word;
  logic [SCALE_W-1:0]    full_scale_mv;

  logic                  out_valid;
  logic signed [MAG_W-1:0] out_raw;
  logic signed [MV_W-1:0]  out_mv;
  logic                  out_err;

  logic [MAG_W-1:0]      count;
  logic                  count_pos;
  logic [MAG_W-1:0]      mag;
  logic [DIV_W-1:0]      divisor;
  logic                  word_err;
  logic [MV_W-1:0]       mv_abs;
  logic                  accept;
  logic                  load;

  sarcv_ctl_t            ctl;
  sarcv_stat_t           stat;

  assign count     = shift_word[MAG_W-1:0];
  assign count_pos = !count[MAG_W-1] && (count != '0);
  assign mag       = count[MAG_W-1] ? (~count + 1'b1) : count;
  assign divisor   = pick_divisor(count_pos, mag);
  assign word_err  = &shift_word;
  assign mv_abs    = MV_W'(stat.mag);

  assign sample.ready = (state == ST_WAIT) || (state == ST_SHIFT);
  assign accept       = sample.valid && sample.ready;
  assign load         = (state == ST_CALC) && stat.done && (!out_valid || result.ready);

  assign ctl.start = state == ST_START;
  assign ctl.take  = load;

  assign cfg.ready = 1'b1;

  sarcv_muldiv u_muldiv (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .mag     (mag),
    .scale   (full_scale_mv),
    .divisor (divisor),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale_mv <= SCALE_RESET;
    end else if (cfg.valid) begin
      full_scale_mv <= cfg.full_scale_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_WAIT;
      bit_count  <= '0;
      shift_word <= '0;
    end else begin
      case (state)
        ST_WAIT: begin
          if (accept && !sample.line_level) begin
            state      <= ST_SHIFT;
            bit_count  <= '0;
            shift_word <= '0;
          end
        end
        ST_SHIFT: begin
          if (accept) begin
            shift_word <= {shift_word[FRAME_BITS-2:0], sample.line_level};
            bit_count  <= bit_count + 1'b1;
            if (bit_count == LAST_BIT) begin
              state     <= ST_START;
              bit_count <= '0;
            end
          end
        end
        ST_START: state <= ST_CALC;
        ST_CALC: begin
          if (load) state <= ST_WAIT;
        end
        default: state <= ST_WAIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_raw <= count;
      out_err <= word_err;
      if (word_err) begin
        out_mv <= '0;
      end else if (count[MAG_W-1]) begin
        out_mv <= ~mv_abs + 1'b1;
      end else begin
        out_mv <= mv_abs;
      end
    end
  end

  assign result.valid      = out_valid;
  assign result.raw_count  = out_raw;
  assign result.millivolts = out_mv;
  assign result.read_error = out_err;

endmodule
`default_nettype wire

>>> hw/rtl/sarcv_checker.sv
`default_nettype none
`include "serial_adc_read_calibrated_volts_top_defines.svh"
module sarcv_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               r_valid,
  input wire logic               r_ready,
  input wire logic signed [21:0] r_raw,
  input wire logic signed [20:0] r_mv,
  input wire logic               r_err
);

  `SARCV_ASSERT(a_valid_holds, r_valid && !r_ready |=> r_valid, "result valid dropped")
  `SARCV_ASSERT(a_payload_holds, r_valid && !r_ready |=> $stable(r_raw) && $stable(r_mv) && $stable(r_err), "result payload changed under stall")
  `SARCV_ASSERT_IMPLY(a_err_zero_mv, r_valid && r_err, r_mv == 21'sd0, "read error with nonzero millivolts")
  `SARCV_ASSERT_IMPLY(a_sign_pos, r_valid && (r_raw > 22'sd0), r_mv >= 21'sd0, "positive count gave negative millivolts")
  `SARCV_ASSERT_IMPLY(a_sign_neg, r_valid && (r_raw <= 22'sd0), r_mv <= 21'sd0, "nonpositive count gave positive millivolts")

endmodule

bind serial_adc_read_calibrated_volts_top sarcv_checker u_sarcv_checker (
  .clk     (clk),
  .rst     (rst),
  .r_valid (result.valid),
  .r_ready (result.ready),
  .r_raw   (result.raw_count),
  .r_mv    (result.millivolts),
  .r_err   (result.read_error)
);
`default_nettype wire

>>> sim/tb_serial_adc_read_calibrated_volts_top.sv
`timescale 1ns / 1ps
module tb_serial_adc_read_calibrated_volts_top;
  import sarcv_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_FRAMES = 8;
  localparam int SCALE_PHASES = 6;
  localparam longint VOLT_CAP = 1000000;

  typedef struct {
    logic signed [21:0] raw_count;
    logic signed [20:0] millivolts;
    logic               read_error;
  } reading_t;

  logic clk;
  logic rst;

  sarcv_sample_if sample_ch();
  sarcv_result_if result_ch();
  sarcv_cfg_if    cfg_ch();

  serial_adc_read_calibrated_volts_top dut (
    .clk(clk),
    .rst(rst),
    .sample(sample_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  int pos_divisors [CHAIN_LEN] = '{
    10850, 10839, 10759, 10711, 10669, 10675, 10733,
    10734, 10712, 10731, 10830, 11100, 11850, 13200
  };
  int neg_divisors [CHAIN_LEN] = '{
    10850, 10835, 10760, 10713, 10676, 10671, 10676,
    11659, 10696, 10638, 10705, 10538, 10750, 11300
  };

  logic     line_levels_to_send [$];
  reading_t expected_readings [$];

  logic [15:0] full_scale = 16'd5000;
  logic        shifting = 1'b0;
  int          bits_in = 0;
  logic [23:0] frame_word = '0;

  int   errors = 0;
  int   readings_checked = 0;
  int   error_frames = 0;
  int   clipped_frames = 0;
  int   levels_sent = 0;
  int   quiet_cycles = 0;
  int   send_hold = 0;
  int   recv_stall = 0;
  logic sender_steady = 1'b0;
  logic receiver_steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.line_level = 1'b0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.full_scale_mv = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic int divisor_for(input logic positive, input int mag);
    for (int i = 0; i < CHAIN_LEN - 1; i++) begin
      if (positive && mag > pos_divisors[i+1]) return pos_divisors[i];
      if (!positive && mag > neg_divisors[i+1]) return neg_divisors[i];
    end
    return positive ? pos_divisors[CHAIN_LEN-1] : neg_divisors[CHAIN_LEN-1];
  endfunction

  task automatic take_line_level(input logic lvl);
    int       count;
    int       div;
    longint   volts;
    reading_t r;
    if (!shifting) begin
      if (!lvl) begin
        shifting = 1'b1;
        bits_in = 0;
        frame_word = '0;
      end
      return;
    end
    frame_word = {frame_word[22:0], lvl};
    bits_in++;
    if (bits_in < FRAME_BITS) return;
    shifting = 1'b0;
    bits_in = 0;
    count = int'($signed(frame_word[21:0]));
    r.raw_count = count[21:0];
    r.read_error = (frame_word == 24'hFFFFFF);
    volts = 0;
    if (!r.read_error) begin
      div = (count > 0) ? divisor_for(1'b1, count) : divisor_for(1'b0, -count);
      volts = longint'(count) * longint'(full_scale) / longint'(div);
      if (volts > VOLT_CAP || volts < -VOLT_CAP) clipped_frames++;
      if (volts > VOLT_CAP) volts = VOLT_CAP;
      if (volts < -VOLT_CAP) volts = -VOLT_CAP;
    end else begin
      error_frames++;
    end
    r.millivolts = volts[20:0];
    expected_readings.push_back(r);
  endtask

  function automatic int pick_gap(input logic steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_reading();
    reading_t want;
    if (expected_readings.size() == 0) begin
      report_mismatch($sformatf("unexpected reading, raw_count %0d", result_ch.raw_count));
      return;
    end
    want = expected_readings.pop_front();
    readings_checked++;
    if (result_ch.raw_count !== want.raw_count)
      report_mismatch($sformatf("raw_count got %0d want %0d",
                                result_ch.raw_count, want.raw_count));
    if (result_ch.millivolts !== want.millivolts)
      report_mismatch($sformatf("millivolts got %0d want %0d (raw_count %0d)",
                                result_ch.millivolts, want.millivolts, want.raw_count));
    if (result_ch.read_error !== want.read_error)
      report_mismatch($sformatf("read_error got %0b want %0b (raw_count %0d)",
                                result_ch.read_error, want.read_error, want.raw_count));
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      sample_ch.line_level <= 1'b0;
      send_hold = 0;
      shifting = 1'b0;
      bits_in = 0;
      frame_word = '0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        take_line_level(sample_ch.line_level);
        void'(line_levels_to_send.pop_front());
        levels_sent++;
        send_hold = pick_gap(sender_steady);
      end
      if (!(sample_ch.valid && !sample_ch.ready)) begin
        if (send_hold > 0) begin
          sample_ch.valid <= 1'b0;
          send_hold--;
        end else if (line_levels_to_send.size() != 0) begin
          sample_ch.valid <= 1'b1;
          sample_ch.line_level <= line_levels_to_send[0];
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) check_reading();
      if (recv_stall > 0) begin
        result_ch.ready <= 1'b0;
        recv_stall--;
      end else begin
        result_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_stall = pick_gap(receiver_steady);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[serial_adc_read_calibrated_volts_top] ERROR");
        $finish;
      end
    end
  end

  task automatic queue_noise(input int n);
    repeat (n) line_levels_to_send.push_back(1'b1);
  endtask

  task automatic queue_frame(input logic [23:0] w);
    line_levels_to_send.push_back(1'b0);
    for (int i = FRAME_BITS - 1; i >= 0; i--) line_levels_to_send.push_back(w[i]);
  endtask

  function automatic logic [23:0] random_word();
    int          pick;
    int          mag;
    logic [21:0] c;
    logic [1:0]  top;
    pick = $urandom_range(0, 99);
    top = 2'($urandom_range(0, 3));
    if (pick < 5) return 24'hFFFFFF;
    if (pick < 35) begin
      // land on and around the divisor thresholds
      if ($urandom_range(0, 1))
        mag = pos_divisors[$urandom_range(0, CHAIN_LEN - 1)];
      else
        mag = neg_divisors[$urandom_range(0, CHAIN_LEN - 1)];
      mag = mag + int'($urandom_range(0, 4)) - 2;
      c = 22'($urandom_range(0, 1) ? mag : -mag);
    end else if (pick < 50) begin
      c = 22'(int'($urandom_range(0, 40)) - 20);
    end else if (pick < 55) begin
      case ($urandom_range(0, 3))
        0: c = 22'h1FFFFF;
        1: c = 22'h200000;
        2: c = 22'h3FFFFF;
        default: c = 22'h000001;
      endcase
    end else begin
      c = 22'($urandom());
    end
    return {top, c};
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (line_levels_to_send.size() != 0 || expected_readings.size() != 0 || sample_ch.valid);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_full_scale(input logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.full_scale_mv <= v;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    full_scale = v;
  endtask

  initial begin
    logic [15:0] next_scale;
    wait (!rst);
    @(negedge clk);
    queue_noise(2);
    queue_frame(24'h000000);
    queue_frame(24'hFFFFFF);
    queue_frame(24'h1FFFFF);
    queue_noise(1);
    queue_frame(24'h200000);
    queue_frame(24'hC00005);
    queue_frame(24'h3FFFFF);
    queue_frame(24'h7FFFFF);
    wait_drained();
    for (int p = 0; p < SCALE_PHASES; p++) begin
      case (p)
        0: next_scale = 16'd65535;
        1: next_scale = 16'd1;
        2: next_scale = 16'd0;
        3: next_scale = 16'd5000;
        default: next_scale = 16'($urandom_range(1, 65535));
      endcase
      sender_steady = (p == 1);
      receiver_steady = (p == 3);
      write_full_scale(next_scale);
      @(negedge clk);
      for (int f = 0; f < RANDOM_FRAMES; f++) begin
        if ($urandom_range(0, 3) == 0) queue_noise($urandom_range(1, 3));
        queue_frame(random_word());
      end
      wait_drained();
    end
    $display("sent %0d line levels, checked %0d readings over %0d scale settings",
             levels_sent, readings_checked, SCALE_PHASES + 1);
    $display("read errors %0d, clipped voltages %0d, mismatches %0d",
             error_frames, clipped_frames, errors);
    if (errors == 0) begin
      $display("[serial_adc_read_calibrated_volts_top] OK");
    end else begin
      $display("[serial_adc_read_calibrated_volts_top] ERROR");
    end
    $finish;
  end

endmodule
